### rtl/core/qos_priority_packet_queues_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef QOS_PRIORITY_PACKET_QUEUES_UNIT_ASSERT_SVH
`define QOS_PRIORITY_PACKET_QUEUES_UNIT_ASSERT_SVH

// Check a property on the rising edge of clk, skipped while reset is held.
`define QPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a signal holds in the cycle after a condition.
`define QPQ_ASSERT_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

### rtl/core/qpq_pkg.sv
// ----------------------------------------------------------------------------
// qpq_pkg
// Shared types and codes of the strict priority packet queue scheduler.
// ----------------------------------------------------------------------------
package qpq_pkg;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_SENT  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	localparam logic REQ_RECEIVE = 1'b0;
	localparam logic REQ_SEND    = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [15:0] packet_handle;
		logic [2:0]  packet_priority;
		logic [6:0]  send_count;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] out_handle;
		logic [2:0]  out_priority;
		logic [5:0]  dropped_count;
		logic        last;
	} out_word_t;

	// Classified command handed from front to back.
	typedef struct packed {
		logic        is_send;
		logic        prio_ok;
		logic [15:0] handle;
		logic [2:0]  prio;
		logic [6:0]  limit;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_THIN_RD,
		ST_THIN_WR,
		ST_APPEND,
		ST_ACK,
		ST_PICK,
		ST_EMIT
	} state_t;

endpackage

### rtl/core/qpq_ram.sv
// ----------------------------------------------------------------------------
// qpq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module qpq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### rtl/core/qpq_front.sv
// ----------------------------------------------------------------------------
// qpq_front
// Accept request words, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module qpq_front #(
	parameter int NUM_LEVELS = 8,
	parameter int MAX_SEND   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  qpq_pkg::in_word_t req,
	output logic              cmd_valid,
	output qpq_pkg::cmd_t     cmd,
	input  logic              cmd_pop
);
	import qpq_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cls;

	assign req_stall = (count_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_q];

	always_comb begin
		cls.is_send = (req.req_type == REQ_SEND);
		cls.prio_ok = (32'(req.packet_priority) < NUM_LEVELS);
		cls.handle  = req.packet_handle;
		cls.prio    = req.packet_priority;
		// clip the send count to the largest burst
		cls.limit   = (32'(req.send_count) > MAX_SEND) ? 7'(MAX_SEND) : req.send_count;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule

### rtl/core/qpq_back.sv
// ----------------------------------------------------------------------------
// qpq_back
// Execute commands: append and thin level rings, serve sends by priority.
// ----------------------------------------------------------------------------
module qpq_back #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  qpq_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output qpq_pkg::out_word_t rsp
);
	import qpq_pkg::*;

	localparam int LVW   = $clog2(NUM_LEVELS);
	localparam int HW    = $clog2(QUEUE_DEPTH);
	localparam int LENW  = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH = NUM_LEVELS * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int KEPT  = QUEUE_DEPTH - QUEUE_DEPTH / 2;
	localparam int HALF  = QUEUE_DEPTH / 2;

	state_t            state_q, state_d;
	logic [LENW-1:0]   len_q  [NUM_LEVELS];
	logic [HW-1:0]     head_q [NUM_LEVELS];
	cmd_t              cmd_q;
	logic [LVW-1:0]    lvl_q;
	logic [HW-1:0]     k_q;
	logic [6:0]        sent_q;
	logic [1:0]        kind_q;
	logic [5:0]        dropped_q;
	logic              last_q;
	out_word_t         rsp_q;
	logic              rsp_valid_q;

	logic              out_ready;
	logic [LVW-1:0]    rcv_lvl;
	logic              rcv_full;
	logic [NUM_LEVELS-1:0] nonempty;
	logic              any_ne;
	logic [LVW-1:0]    pick_lvl;
	logic              pick_last;
	logic              rsp_load;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [15:0]       ram_wdata, ram_rdata;

	function automatic logic [AW-1:0] slot_addr(input logic [LVW-1:0] lvl,
	                                            input logic [HW-1:0] head,
	                                            input logic [HW:0] off);
		logic [HW:0] sum;
		sum = {1'b0, head} + off;
		if (sum >= (HW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (HW+1)'(QUEUE_DEPTH);
		end
		return AW'(lvl) * AW'(QUEUE_DEPTH) + AW'(sum[HW-1:0]);
	endfunction

	qpq_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_ready = !rsp_valid_q || !rsp_stall;
	assign rcv_lvl   = LVW'(cmd.prio);
	assign rcv_full  = (len_q[rcv_lvl] == LENW'(QUEUE_DEPTH));

	always_comb begin
		pick_lvl = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			nonempty[l] = (len_q[l] != '0);
			if (nonempty[l]) begin
				pick_lvl = LVW'(l);
			end
		end
		any_ne = |nonempty;
		pick_last = !((|(nonempty & ~(NUM_LEVELS'(1) << pick_lvl)))
		              || (len_q[pick_lvl] > LENW'(1)))
		            || (sent_q + 7'd1 == cmd_q.limit);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.is_send) begin
						state_d = (cmd.limit == 7'd0 || !any_ne) ? ST_ACK : ST_PICK;
					end else if (!cmd.prio_ok) begin
						state_d = ST_ACK;
					end else if (rcv_full && KEPT > 1) begin
						state_d = ST_THIN_RD;
					end else begin
						state_d = ST_APPEND;
					end
				end
			end
			ST_THIN_RD: state_d = ST_THIN_WR;
			ST_THIN_WR: state_d = (k_q + HW'(1) == HW'(KEPT)) ? ST_APPEND : ST_THIN_RD;
			ST_APPEND:  state_d = ST_ACK;
			ST_ACK:     state_d = out_ready ? ST_IDLE : ST_ACK;
			ST_PICK:    state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_ready) begin
					state_d = last_q ? ST_IDLE : ST_PICK;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = '0;
		ram_raddr = '0;
		ram_wdata = cmd_q.handle;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: cmd_pop = cmd_valid;
			ST_THIN_RD: begin
				ram_re    = 1'b1;
				ram_raddr = slot_addr(lvl_q, head_q[lvl_q], {k_q, 1'b0});
			end
			ST_THIN_WR: begin
				ram_we    = 1'b1;
				ram_waddr = slot_addr(lvl_q, head_q[lvl_q], {1'b0, k_q});
				ram_wdata = ram_rdata;
			end
			ST_APPEND: begin
				ram_we    = 1'b1;
				ram_waddr = slot_addr(lvl_q, head_q[lvl_q], (HW+1)'(len_q[lvl_q]));
			end
			ST_ACK: rsp_load = out_ready;
			ST_PICK: begin
				ram_re    = 1'b1;
				ram_raddr = slot_addr(pick_lvl, head_q[pick_lvl], '0);
			end
			ST_EMIT: rsp_load = out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q     <= cmd;
			lvl_q     <= rcv_lvl;
			k_q       <= HW'(1);
			sent_q    <= 7'd0;
			kind_q    <= cmd.is_send ? KIND_EMPTY : KIND_ACK;
			dropped_q <= (!cmd.is_send && cmd.prio_ok && rcv_full) ? 6'(HALF) : 6'd0;
		end
		if (state_q == ST_THIN_WR) begin
			k_q <= k_q + HW'(1);
		end
		if (state_q == ST_PICK) begin
			lvl_q  <= pick_lvl;
			sent_q <= sent_q + 7'd1;
			last_q <= pick_last;
		end
		if (rsp_load) begin
			if (state_q == ST_EMIT) begin
				rsp_q <= '{result_kind: KIND_SENT, out_handle: ram_rdata,
				           out_priority: 3'(lvl_q), dropped_count: 6'd0, last: last_q};
			end else begin
				rsp_q <= '{result_kind: kind_q, out_handle: 16'd0, out_priority: 3'd0,
				           dropped_count: dropped_q, last: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				len_q[l]  <= '0;
				head_q[l] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && cmd_valid && !cmd.is_send && cmd.prio_ok
			    && rcv_full) begin
				len_q[rcv_lvl] <= LENW'(KEPT);
			end
			if (state_q == ST_APPEND) begin
				len_q[lvl_q] <= len_q[lvl_q] + LENW'(1);
			end
			if (state_q == ST_PICK) begin
				len_q[pick_lvl]  <= len_q[pick_lvl] - LENW'(1);
				head_q[pick_lvl] <= (head_q[pick_lvl] == HW'(QUEUE_DEPTH - 1)) ? '0
				                    : head_q[pick_lvl] + HW'(1);
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

### rtl/core/qos_priority_packet_queues_unit.sv
// ----------------------------------------------------------------------------
// qos_priority_packet_queues_unit
// Strict priority packet queue scheduler with one ring of handles per level.
// ----------------------------------------------------------------------------
// Channel | Valid     | Stall     | Word  | Carries
// request | req_valid | req_stall | req   | receive or send request
// result  | rsp_valid | rsp_stall | rsp   | ack, sent handle or empty mark
//
// A receive passes through idle, append and ack; on a full level thinning first
// moves KEPT-1 entries, one store read and one store write per moved entry.
// A send passes through idle, then pick (and read) and emit per handle sent;
// a send that moves nothing, or a receive beyond the built levels, goes to ack.
// Reset clears level lengths and heads; the handle store needs no clearing.
// A stalled result holds the back end; the two-entry command queue keeps
// taking request words until it fills.
// ----------------------------------------------------------------------------
module qos_priority_packet_queues_unit #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_SEND    = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  qpq_pkg::in_word_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output qpq_pkg::out_word_t rsp
);
	import qpq_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// front: accept and classify request words
	qpq_front #(.NUM_LEVELS(NUM_LEVELS), .MAX_SEND(MAX_SEND)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: run the queue operations and drive result words
	qpq_back #(.NUM_LEVELS(NUM_LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);
endmodule

### rtl/core/qpq_checker.sv
// ----------------------------------------------------------------------------
// qpq_checker
// Port level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "qos_priority_packet_queues_unit_assert.svh"

module qpq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input qpq_pkg::out_word_t rsp
);
	import qpq_pkg::*;

	`QPQ_ASSERT_HOLD(a_rsp_hold, rsp_valid && rsp_stall, rsp, "stalled result word changed")
	`QPQ_ASSERT(a_kind_legal, rsp_valid |-> (rsp.result_kind != 2'd3), "illegal result kind")
	`QPQ_ASSERT(a_single_last, rsp_valid && rsp.result_kind != KIND_SENT |-> rsp.last, "ack or empty without last")
	`QPQ_ASSERT(a_sent_clean, rsp_valid && rsp.result_kind != KIND_ACK |-> (rsp.dropped_count == 6'd0), "drop count outside ack")
endmodule

bind qos_priority_packet_queues_unit qpq_checker u_qpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
